### sv/pas_pkg.sv
// Shared types, constants and character helpers for the PEM armor scanner.
// Depends on nothing; every other file imports it.
package pas_pkg;

    localparam int MAX_LABEL_DEF   = 64;
    localparam int OFFSET_BITS_DEF = 24;
    localparam int OUT_OFF_W       = 24;
    localparam int LEN_W           = 7;
    localparam int FIFO_DEPTH      = 4;
    localparam int Q_AW            = 2;

    localparam int BEGIN_LEN = 11;
    localparam int END_LEN   = 9;
    localparam int TRAIL_LEN = 5;

    localparam logic [1:0] PH_PREFIX  = 2'd0;
    localparam logic [1:0] PH_LABEL   = 2'd1;
    localparam logic [1:0] PH_TRAIL   = 2'd2;
    localparam logic [1:0] PH_MATCHED = 2'd3;

    localparam logic KIND_BLOCK = 1'b0;
    localparam logic KIND_DONE  = 1'b1;

    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_DASH = 8'h2D;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic                 result_kind;
        logic [OUT_OFF_W-1:0] label_start;
        logic [LEN_W-1:0]     label_length;
        logic [OUT_OFF_W-1:0] body_start;
        logic [OUT_OFF_W-1:0] body_length;
        logic [OUT_OFF_W-1:0] block_end;
        logic                 label_overflow;
        logic                 last_result;
    } t_out_word;

    typedef struct packed {
        logic                 has_block;
        logic                 has_done;
        logic [OUT_OFF_W-1:0] label_start;
        logic [LEN_W-1:0]     label_length;
        logic [OUT_OFF_W-1:0] body_start;
        logic [OUT_OFF_W-1:0] body_length;
        logic [OUT_OFF_W-1:0] block_end;
        logic                 overflow;
    } t_event;

    typedef struct packed {
        logic   valid;
        t_event ev;
    } t_ev_push;

    function automatic logic [7:0] begin_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0, 4'd1, 4'd2, 4'd3, 4'd4: c = CH_DASH;
            4'd5:    c = "B";
            4'd6:    c = "E";
            4'd7:    c = "G";
            4'd8:    c = "I";
            4'd9:    c = "N";
            4'd10:   c = " ";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] end_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0, 4'd1, 4'd2, 4'd3, 4'd4: c = CH_DASH;
            4'd5:    c = "E";
            4'd6:    c = "N";
            4'd7:    c = "D";
            4'd8:    c = " ";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic is_label_byte(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
               (c >= "0" && c <= "9") || c == " " || (c >= 8'h09 && c <= 8'h0D);
    endfunction

endpackage

### sv/pas_front.sv
// Front end: line matcher, label store and offsets; one byte per cycle unless full.
// Emits one event word per byte that closes a block or ends the stream. Uses pas_pkg.
module pas_front #(
    parameter int MAX_LABEL   = pas_pkg::MAX_LABEL_DEF,
    parameter int OFFSET_BITS = pas_pkg::OFFSET_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic              i_q_full,
    input  pas_pkg::t_in_word i_in,
    output pas_pkg::t_ev_push o_push
);
    import pas_pkg::*;

    localparam int PI_W = ($clog2(MAX_LABEL + 2) > 4) ? $clog2(MAX_LABEL + 2) : 4;
    localparam int AW   = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
    localparam int OW   = (OFFSET_BITS > OUT_OFF_W) ? OFFSET_BITS : OUT_OFF_W;
    localparam int LW   = (PI_W > LEN_W) ? PI_W : LEN_W;
    localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

    logic                   r_mode, n_mode;
    logic [1:0]             r_phase, n_phase;
    logic [PI_W-1:0]        r_idx, n_idx;
    logic                   r_ok, n_ok;
    logic [OFFSET_BITS-1:0] r_off, n_off;
    logic [OFFSET_BITS-1:0] r_ls, n_ls;
    logic [PI_W-1:0]        r_bll, n_bll;
    logic [OFFSET_BITS-1:0] r_sls, n_sls;
    logic [OFFSET_BITS-1:0] r_sbs, n_sbs;
    logic                   r_ovf, n_ovf;

    logic [7:0]             mem [MAX_LABEL];
    logic [7:0]             r_rd;

    logic                   accept;
    logic [7:0]             b;
    logic                   wr_en;
    logic                   ev_block;
    logic                   ovf_now;
    logic [OFFSET_BITS-1:0] off_inc;
    logic [OFFSET_BITS:0]   ls_sum;
    logic [OFFSET_BITS-1:0] ls11;
    logic [OFFSET_BITS-1:0] body_len;
    logic [7:0]             pchar;
    logic [PI_W-1:0]        plen;
    logic [OW-1:0]          sls_w, sbs_w, blen_w, end_w;
    logic [LW-1:0]          bll_w;

    assign accept = i_push && !i_q_full;
    assign b      = i_in.data_byte;
    assign off_inc = (r_off == OFF_MAX) ? OFF_MAX : r_off + 1'b1;
    assign ls_sum = {1'b0, r_ls} + (OFFSET_BITS + 1)'(BEGIN_LEN);
    assign ls11   = ls_sum[OFFSET_BITS] ? OFF_MAX : ls_sum[OFFSET_BITS-1:0];
    assign body_len = (r_ls > r_sbs) ? (r_ls - r_sbs - 1'b1) : '0;
    assign pchar  = r_mode ? end_char(r_idx[3:0]) : begin_char(r_idx[3:0]);
    assign plen   = r_mode ? PI_W'(END_LEN) : PI_W'(BEGIN_LEN);

    always_comb begin
        n_mode   = r_mode;
        n_phase  = r_phase;
        n_idx    = r_idx;
        n_ok     = r_ok;
        n_off    = r_off;
        n_ls     = r_ls;
        n_bll    = r_bll;
        n_sls    = r_sls;
        n_sbs    = r_sbs;
        n_ovf    = r_ovf;
        wr_en    = 1'b0;
        ev_block = 1'b0;
        ovf_now  = r_ovf;
        if (accept) begin
            n_off = off_inc;
            if (b == CH_LF) begin
                if (r_ok && r_phase == PH_MATCHED) begin
                    if (!r_mode) begin
                        if (r_bll > PI_W'(MAX_LABEL)) begin
                            n_ovf   = 1'b1;
                            ovf_now = 1'b1;
                        end else begin
                            n_sls  = ls11;
                            n_sbs  = off_inc;
                            n_mode = 1'b1;
                        end
                    end else begin
                        ev_block = 1'b1;
                        n_mode   = 1'b0;
                    end
                end
                n_phase = PH_PREFIX;
                n_idx   = '0;
                n_ok    = 1'b1;
                n_ls    = off_inc;
            end else if (r_ok) begin
                unique case (r_phase)
                    PH_PREFIX: begin
                        if (r_idx < plen && b == pchar) begin
                            if (r_idx + 1'b1 == plen) begin
                                n_phase = PH_LABEL;
                                n_idx   = '0;
                            end else begin
                                n_idx = r_idx + 1'b1;
                            end
                        end else begin
                            n_ok = 1'b0;
                        end
                    end
                    PH_LABEL: begin
                        if (is_label_byte(b)) begin
                            if (!r_mode) begin
                                wr_en = (r_idx < PI_W'(MAX_LABEL));
                                if (r_idx <= PI_W'(MAX_LABEL)) n_idx = r_idx + 1'b1;
                            end else if (r_idx < r_bll && r_idx < PI_W'(MAX_LABEL) &&
                                         r_rd == b) begin
                                n_idx = r_idx + 1'b1;
                            end else begin
                                n_ok = 1'b0;
                            end
                        end else if (r_mode && r_idx != r_bll) begin
                            n_ok = 1'b0;
                        end else begin
                            if (!r_mode) n_bll = r_idx;
                            if (b == CH_DASH) begin
                                n_phase = PH_TRAIL;
                                n_idx   = PI_W'(1);
                            end else begin
                                n_ok = 1'b0;
                            end
                        end
                    end
                    PH_TRAIL: begin
                        if (b == CH_DASH) begin
                            n_idx = r_idx + 1'b1;
                            if (r_idx + 1'b1 >= PI_W'(TRAIL_LEN)) n_phase = PH_MATCHED;
                        end else begin
                            n_ok = 1'b0;
                        end
                    end
                    PH_MATCHED: begin
                    end
                endcase
            end
            if (i_in.last_byte) begin
                n_mode  = 1'b0;
                n_phase = PH_PREFIX;
                n_idx   = '0;
                n_ok    = 1'b1;
                n_off   = '0;
                n_ls    = '0;
                n_bll   = '0;
                n_sls   = '0;
                n_sbs   = '0;
                n_ovf   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b0;
            r_phase <= PH_PREFIX;
            r_idx   <= '0;
            r_ok    <= 1'b1;
            r_off   <= '0;
            r_ls    <= '0;
            r_bll   <= '0;
            r_sls   <= '0;
            r_sbs   <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_ok    <= n_ok;
            r_off   <= n_off;
            r_ls    <= n_ls;
            r_bll   <= n_bll;
            r_sls   <= n_sls;
            r_sbs   <= n_sbs;
            r_ovf   <= n_ovf;
        end
    end

    // prefetch the label byte for the next index
    always_ff @(posedge i_clk) begin
        if (wr_en) mem[r_idx[AW-1:0]] <= b;
        r_rd <= mem[n_idx[AW-1:0]];
    end

    assign sls_w  = OW'(r_sls);
    assign sbs_w  = OW'(r_sbs);
    assign blen_w = OW'(body_len);
    assign end_w  = OW'(off_inc);
    assign bll_w  = LW'(r_bll);

    always_comb begin
        o_push.valid           = accept && (ev_block || i_in.last_byte);
        o_push.ev.has_block    = ev_block;
        o_push.ev.has_done     = i_in.last_byte;
        o_push.ev.label_start  = sls_w[OUT_OFF_W-1:0];
        o_push.ev.label_length = bll_w[LEN_W-1:0];
        o_push.ev.body_start   = sbs_w[OUT_OFF_W-1:0];
        o_push.ev.body_length  = blen_w[OUT_OFF_W-1:0];
        o_push.ev.block_end    = end_w[OUT_OFF_W-1:0];
        o_push.ev.overflow     = ovf_now;
    end

endmodule

### sv/pas_fifo.sv
// Short event queue between the scanner front and the result back end.
// Register array with head read; uses pas_pkg for the event type and depth.
module pas_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pas_pkg::t_ev_push i_push,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output pas_pkg::t_event   o_head
);
    import pas_pkg::*;

    t_event          mem [FIFO_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_AW:0]   r_count;
    logic            do_push, do_pop;

    assign o_full  = (r_count == (Q_AW + 1)'(FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = mem[r_rd_ptr];
    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (do_pop) r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count <= r_count + (Q_AW + 1)'(do_push) - (Q_AW + 1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) mem[r_wr_ptr] <= i_push.ev;
    end

endmodule

### sv/pas_back.sv
// Back end: expands each queued event into one or two result words.
// Drives the result queue interface; uses pas_pkg.
module pas_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  pas_pkg::t_event    i_head,
    input  logic               i_pop,
    output logic               o_q_pop,
    output logic               o_empty,
    output pas_pkg::t_out_word o_out
);
    import pas_pkg::*;

    logic r_sub;
    logic accept;
    logic two;
    logic show_done;

    assign accept    = i_pop && i_q_valid;
    assign two       = i_head.has_block && i_head.has_done;
    assign show_done = !i_head.has_block || r_sub;
    assign o_empty   = !i_q_valid;
    assign o_q_pop   = accept && !(two && !r_sub);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub <= 1'b0;
        end else if (accept) begin
            r_sub <= two && !r_sub;
        end
    end

    always_comb begin
        if (show_done) begin
            o_out.result_kind    = KIND_DONE;
            o_out.label_start    = '0;
            o_out.label_length   = '0;
            o_out.body_start     = '0;
            o_out.body_length    = '0;
            o_out.block_end      = '0;
            o_out.label_overflow = i_head.overflow;
            o_out.last_result    = 1'b1;
        end else begin
            o_out.result_kind    = KIND_BLOCK;
            o_out.label_start    = i_head.label_start;
            o_out.label_length   = i_head.label_length;
            o_out.body_start     = i_head.body_start;
            o_out.body_length    = i_head.body_length;
            o_out.block_end      = i_head.block_end;
            o_out.label_overflow = 1'b0;
            o_out.last_result    = !i_head.has_done;
        end
    end

endmodule

### sv/pem_armor_scanner_top.sv
// Top level of the PEM armor scanner: front matcher, event queue, result back end.
// Depends on pas_pkg, pas_front, pas_fifo and pas_back.
//
//   channel   direction  handshake     payload
//   input     in         push / full   i_in  (t_in_word: data_byte, last_byte)
//   result    out        empty / pop   o_out (t_out_word)
//
// One byte is taken every cycle while full is low; the front updates the line
// matcher and offsets in that cycle, with the label store read registered for the next index.
// A byte that ends a block or the stream yields one or two result words from a
// four-entry event queue; full rises only when that queue is full.
// Reset is synchronous and active low; no clearing pass is needed.
module pem_armor_scanner_top #(
    parameter int MAX_LABEL   = pas_pkg::MAX_LABEL_DEF,
    parameter int OFFSET_BITS = pas_pkg::OFFSET_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  pas_pkg::t_in_word  i_in,
    output logic               empty,
    input  logic               pop,
    output pas_pkg::t_out_word o_out
);
    import pas_pkg::*;

    t_ev_push ev_push;
    t_event   head;
    logic     q_full;
    logic     q_valid;
    logic     q_pop;

    assign full = q_full;

    pas_front #(
        .MAX_LABEL  (MAX_LABEL),
        .OFFSET_BITS(OFFSET_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_q_full(q_full),
        .i_in    (i_in),
        .o_push  (ev_push)
    );

    pas_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (ev_push),
        .i_pop  (q_pop),
        .o_full (q_full),
        .o_valid(q_valid),
        .o_head (head)
    );

    pas_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(q_valid),
        .i_head   (head),
        .i_pop    (pop),
        .o_q_pop  (q_pop),
        .o_empty  (empty),
        .o_out    (o_out)
    );

endmodule

### bench/tb_pem_armor_scanner_top.sv
`timescale 1ns / 1ps
// Self-checking bench for pem_armor_scanner_top: random PEM-like text streams in,
// result words checked against a bit-accurate scanner model kept in this file.
// Depends on pas_pkg and the scanner RTL.
module tb_pem_armor_scanner_top;
    import pas_pkg::*;

    localparam int LBL_MAX = MAX_LABEL_DEF;

    typedef struct {
        t_in_word w;
        bit       hold;
    } t_text_item;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    t_in_word   in_word = '0;
    logic       empty;
    logic       pop = 1'b0;
    t_out_word  out_word;

    t_text_item text_bytes[$];
    t_out_word  armor_results[$];
    logic [7:0] cur_label[$];

    int  fail_count = 0;
    int  n_bytes = 0;
    int  n_blocks = 0;
    int  n_done = 0;
    int  n_streams = 0;
    int  rx_stall = 0;
    bit  hold_next = 1'b0;
    bit  calm;

    // scanner model state
    bit          in_body;
    logic [1:0]  phase;
    logic [6:0]  pidx;
    bit          line_good;
    logic [23:0] offs;
    logic [23:0] lstart;
    logic [7:0]  lbl [LBL_MAX];
    logic [6:0]  blen;
    logic [23:0] sv_lstart;
    logic [23:0] sv_bstart;
    bit          ovf;

    pem_armor_scanner_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_in    (in_word),
        .empty   (empty),
        .pop     (pop),
        .o_out   (out_word)
    );

    always #1 i_clk = ~i_clk;

    assign calm = (n_bytes >= 300) && (n_bytes < 650);

    function automatic logic [23:0] off_add(logic [23:0] a, int k);
        logic [24:0] s;
        s = {1'b0, a} + 25'(k);
        return s[24] ? 24'hFFFFFF : s[23:0];
    endfunction

    function automatic bit lbl_byte_ok(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
               (c >= "0" && c <= "9") || c == " " || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [7:0] hdr_char(bit body, int idx);
        string s;
        if (body) s = "-----END ";
        else s = "-----BEGIN ";
        return s[idx];
    endfunction

    task automatic scan_reset();
        in_body = 1'b0;
        phase = PH_PREFIX;
        pidx = '0;
        line_good = 1'b1;
        offs = '0;
        lstart = '0;
        blen = '0;
        sv_lstart = '0;
        sv_bstart = '0;
        ovf = 1'b0;
    endtask

    task automatic scan_char(logic [7:0] b);
        int plen;
        plen = in_body ? END_LEN : BEGIN_LEN;
        if (line_good && phase != PH_MATCHED) begin
            case (phase)
                PH_PREFIX: begin
                    if (pidx < plen && b == hdr_char(in_body, int'(pidx))) begin
                        pidx = pidx + 7'd1;
                        if (pidx == plen) begin
                            phase = PH_LABEL;
                            pidx = '0;
                        end
                    end else begin
                        line_good = 1'b0;
                    end
                end
                PH_LABEL: begin
                    if (lbl_byte_ok(b)) begin
                        if (!in_body) begin
                            if (pidx < LBL_MAX) lbl[pidx] = b;
                            if (pidx <= LBL_MAX) pidx = pidx + 7'd1;
                        end else if (pidx < blen && pidx < LBL_MAX && lbl[pidx] == b) begin
                            pidx = pidx + 7'd1;
                        end else begin
                            line_good = 1'b0;
                        end
                    end else begin
                        if (!in_body) blen = pidx;
                        if (in_body && pidx != blen) begin
                            line_good = 1'b0;
                        end else if (b == CH_DASH) begin
                            phase = PH_TRAIL;
                            pidx = 7'd1;
                        end else begin
                            line_good = 1'b0;
                        end
                    end
                end
                default: begin
                    if (b == CH_DASH) begin
                        pidx = pidx + 7'd1;
                        if (pidx >= TRAIL_LEN) phase = PH_MATCHED;
                    end else begin
                        line_good = 1'b0;
                    end
                end
            endcase
        end
    endtask

    task automatic scan_byte(t_in_word w);
        t_out_word   rw[2];
        int          n;
        logic [23:0] nxt;
        n = 0;
        nxt = off_add(offs, 1);
        offs = nxt;
        if (w.data_byte == CH_LF) begin
            if (line_good && phase == PH_MATCHED) begin
                if (!in_body) begin
                    if (blen > LBL_MAX) begin
                        ovf = 1'b1;
                    end else begin
                        sv_lstart = off_add(lstart, BEGIN_LEN);
                        sv_bstart = nxt;
                        in_body = 1'b1;
                    end
                end else begin
                    rw[0] = '0;
                    rw[0].result_kind = KIND_BLOCK;
                    rw[0].label_start = sv_lstart;
                    rw[0].label_length = blen;
                    rw[0].body_start = sv_bstart;
                    rw[0].body_length = (lstart > sv_bstart) ?
                                        lstart - sv_bstart - 24'd1 : '0;
                    rw[0].block_end = nxt;
                    n = 1;
                    in_body = 1'b0;
                end
            end
            phase = PH_PREFIX;
            pidx = '0;
            line_good = 1'b1;
            lstart = nxt;
        end else begin
            scan_char(w.data_byte);
        end
        if (w.last_byte) begin
            rw[n] = '0;
            rw[n].result_kind = KIND_DONE;
            rw[n].label_overflow = ovf;
            n++;
            scan_reset();
        end
        if (n > 0) rw[n-1].last_result = 1'b1;
        for (int i = 0; i < n; i++) armor_results.push_back(rw[i]);
    endtask

    task automatic cmp_field(string name, logic [23:0] e, logic [23:0] a);
        if (e !== a) begin
            $error("%s: expected %0d, got %0d", name, e, a);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (armor_results.size() == 0) begin
                    $error("unexpected result word %h", out_word);
                    fail_count++;
                end else begin
                    want = armor_results.pop_front();
                    cmp_field("result_kind", 24'(want.result_kind),
                              24'(out_word.result_kind));
                    cmp_field("label_start", want.label_start, out_word.label_start);
                    cmp_field("label_length", 24'(want.label_length),
                              24'(out_word.label_length));
                    cmp_field("body_start", want.body_start, out_word.body_start);
                    cmp_field("body_length", want.body_length, out_word.body_length);
                    cmp_field("block_end", want.block_end, out_word.block_end);
                    cmp_field("label_overflow", 24'(want.label_overflow),
                              24'(out_word.label_overflow));
                    cmp_field("last_result", 24'(want.last_result),
                              24'(out_word.last_result));
                    if (want.result_kind == KIND_DONE) n_done++;
                    else n_blocks++;
                end
            end
            if (push && !full) begin
                scan_byte(text_bytes[0].w);
                text_bytes.delete(0);
                n_bytes++;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n || text_bytes.size() == 0) begin
            push <= 1'b0;
        end else if (text_bytes[0].hold && armor_results.size() != 0) begin
            push <= 1'b0;
        end else if (!calm && $urandom_range(0, 99) < 8) begin
            push <= 1'b0;
        end else begin
            push <= 1'b1;
            in_word <= text_bytes[0].w;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall <= rx_stall - 1;
            pop <= 1'b0;
        end else if (!calm && $urandom_range(0, 399) == 0) begin
            rx_stall <= $urandom_range(4, 12);
            pop <= 1'b0;
        end else begin
            pop <= calm || ($urandom_range(0, 99) >= 8);
        end
    end

    task automatic put_byte(logic [7:0] b);
        t_text_item it;
        it.w.data_byte = b;
        it.w.last_byte = 1'b0;
        it.hold = hold_next;
        hold_next = 1'b0;
        text_bytes.push_back(it);
    endtask

    task automatic put_str(string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endtask

    task automatic end_stream();
        t_text_item it;
        if (text_bytes.size() == 0) put_byte(8'($urandom_range(0, 255)));
        it = text_bytes.pop_back();
        it.w.last_byte = 1'b1;
        text_bytes.push_back(it);
        n_streams++;
    endtask

    task automatic make_label(int n);
        int         r;
        logic [7:0] c;
        cur_label.delete();
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 40) c = 8'("A" + $urandom_range(0, 25));
            else if (r < 65) c = 8'("a" + $urandom_range(0, 25));
            else if (r < 85) c = 8'("0" + $urandom_range(0, 9));
            else if (r < 93) c = " ";
            else if (r < 96) c = 8'h09;
            else c = 8'(8'h0B + $urandom_range(0, 2));
            cur_label.push_back(c);
        end
    endtask

    task automatic put_eol(bit cr);
        if (cr) put_byte(8'h0D);
        put_byte(CH_LF);
    endtask

    task automatic put_begin(int n, bit cr);
        put_str("-----BEGIN ");
        make_label(n);
        foreach (cur_label[i]) put_byte(cur_label[i]);
        put_str("-----");
        if ($urandom_range(0, 9) == 0) put_str("--x");
        put_eol(cr);
    endtask

    task automatic put_end(int kind, bit cr);
        logic [7:0] lab[$];
        int         k;
        lab = cur_label;
        case (kind)
            1: begin
                if (lab.size() == 0) begin
                    lab.push_back("Z");
                end else begin
                    k = $urandom_range(0, lab.size() - 1);
                    lab[k] = (lab[k] == "Z") ? "Y" : "Z";
                end
            end
            2: begin
                if (lab.size() > 0 && $urandom_range(0, 1)) void'(lab.pop_back());
                else lab.push_back("Q");
            end
            default: ;
        endcase
        if (kind == 3) put_str("----END ");
        else put_str("-----END ");
        foreach (lab[i]) put_byte(lab[i]);
        if (kind == 4) put_str("----");
        else put_str("-----");
        put_eol(cr);
    endtask

    task automatic put_body_line();
        int         r;
        logic [7:0] c;
        if ($urandom_range(0, 19) == 0) begin
            put_str("-----BEGIN X-----");
        end else begin
            repeat ($urandom_range(0, 24)) begin
                r = $urandom_range(0, 99);
                if (r < 40) c = 8'("A" + $urandom_range(0, 25));
                else if (r < 70) c = 8'("a" + $urandom_range(0, 25));
                else if (r < 85) c = 8'("0" + $urandom_range(0, 9));
                else if (r < 90) c = (r < 88) ? "+" : "/";
                else c = 8'($urandom_range(0, 255));
                put_byte(c);
            end
        end
        put_eol($urandom_range(0, 3) == 0);
    endtask

    task automatic put_block();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) put_begin($urandom_range(0, 10), 1'($urandom_range(0, 1)));
        else if (r < 92) put_begin($urandom_range(60, LBL_MAX), 1'($urandom_range(0, 1)));
        else put_begin($urandom_range(LBL_MAX + 1, LBL_MAX + 4), 1'($urandom_range(0, 1)));
        repeat ($urandom_range(0, 3)) put_body_line();
        while ($urandom_range(0, 3) == 0) put_end($urandom_range(1, 4), 1'($urandom_range(0, 1)));
        put_end(0, 1'($urandom_range(0, 1)));
    endtask

    task automatic put_stream();
        int         r;
        logic [7:0] b;
        if ($urandom_range(0, 99) < 15) begin
            repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(1, 3)) begin
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    put_block();
                end else if (r < 75) begin
                    case ($urandom_range(0, 2))
                        0: put_str("-----BEGI");
                        1: put_str("-----BEGIN ABC----");
                        default: put_str("-----BEGIN AB?C-----");
                    endcase
                    put_byte(CH_LF);
                end else if (r < 85) begin
                    put_body_line();
                end else begin
                    put_end(0, 1'($urandom_range(0, 1)));
                end
            end
            r = $urandom_range(0, 99);
            if (r >= 60 && r < 75) begin
                repeat ($urandom_range(1, 6)) begin
                    b = 8'($urandom_range(0, 255));
                    put_byte(b == CH_LF ? 8'h20 : b);
                end
            end else if (r >= 75 && r < 90) begin
                put_begin($urandom_range(0, 6), 1'b0);
                put_body_line();
            end
        end
        end_stream();
    endtask

    initial begin
        int k;
        scan_reset();
        put_str("-----BEGIN -----");
        put_eol(1'b1);
        put_str("x");
        put_byte(CH_LF);
        put_str("-----END -----");
        put_byte(CH_LF);
        end_stream();
        put_byte(8'hFF);
        end_stream();
        put_byte(8'h00);
        end_stream();
        while (text_bytes.size() < 1100) begin
            if (n_streams % 12 == 11) hold_next = 1'b1;
            put_stream();
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (text_bytes.size() != 0) @(posedge i_clk);
        for (k = 0; k < 20000 && armor_results.size() != 0; k++) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (armor_results.size() != 0) begin
            $error("%0d result words never arrived", armor_results.size());
            fail_count += armor_results.size();
        end

        $display("Scanned %0d bytes in %0d streams: %0d armor blocks and %0d end-of-stream words",
                 n_bytes, n_streams, n_blocks, n_done);
        $display("Mix: bad END labels, overlong labels, unclosed blocks, stalls and drains");
        if (fail_count == 0) begin
            $display("** pem_armor_scanner_top: PASSED **");
        end else begin
            $display("** pem_armor_scanner_top: FAILED **");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("** pem_armor_scanner_top: FAILED **");
        $finish;
    end

endmodule

### pem_armor_scanner_top.f
sv/pas_pkg.sv
sv/pas_front.sv
sv/pas_fifo.sv
sv/pas_back.sv
sv/pem_armor_scanner_top.sv
bench/tb_pem_armor_scanner_top.sv
